@@ rtl/gii_pkg.sv @@
// Shared types and constants for the guarded input inject/drain block.
// Used by the channel interfaces, the drain unit and the top level.
package gii_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BIT_W = 5;
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [WORD_W-1:0] CAP_LIMIT = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		ST_BAD    = 2'd0,
		ST_PASS   = 2'd1,
		ST_STALE  = 2'd2,
		ST_INJECT = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC     = 3'd0,
		CFG_VERSION   = 3'd1,
		CFG_TIMEOUT   = 3'd2,
		CFG_CHAN_MASK = 3'd3,
		CFG_MOUSE_BIT = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [WORD_W-1:0]        seq_before;
		logic [WORD_W-1:0]        seq_after;
		logic [WORD_W-1:0]        header_magic;
		logic [WORD_W-1:0]        header_version;
		logic                     enabled;
		logic [WORD_W-1:0]        channels;
		logic [WORD_W-1:0]        writer_tick;
		logic [WORD_W-1:0]        now_ms;
		logic [WORD_W-1:0]        mouse_seq;
		logic signed [WORD_W-1:0] budget_x;
		logic signed [WORD_W-1:0] budget_y;
		logic [WORD_W-1:0]        step_max;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [WORD_W-1:0]        seq_seen;
		logic [WORD_W-1:0]        channels_out;
		logic signed [WORD_W-1:0] mouse_dx;
		logic signed [WORD_W-1:0] mouse_dy;
		logic [WORD_W-1:0]        frame_count;
		logic [WORD_W-1:0]        applied_count;
		logic signed [WORD_W-1:0] left_x;
		logic signed [WORD_W-1:0] left_y;
	} out_beat_t;

endpackage

@@ rtl/gii_in_if.sv @@
// Valid/ready channel carrying one frame snapshot beat.
// Depends on gii_pkg for the beat type.
interface gii_in_if;
	logic             valid;
	logic             ready;
	gii_pkg::in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/gii_out_if.sv @@
// Valid/ready channel carrying one result beat.
// Depends on gii_pkg for the beat type.
interface gii_out_if;
	logic              valid;
	logic              ready;
	gii_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/gii_drain.sv @@
// Capped signed drain of one budget axis: step and remainder after it.
// Depends on gii_pkg for widths and the cap limit.
module gii_drain (
	input  logic signed [gii_pkg::WORD_W-1:0] rem,
	input  logic        [gii_pkg::WORD_W-1:0] cap_in,
	output logic signed [gii_pkg::WORD_W-1:0] step,
	output logic signed [gii_pkg::WORD_W-1:0] left
);
	logic signed [gii_pkg::WORD_W-1:0] cap;
	logic signed [gii_pkg::WORD_W-1:0] neg_cap;

	// cap never exceeds the positive limit, so its negation always fits
	assign cap = (cap_in > gii_pkg::CAP_LIMIT) ? gii_pkg::CAP_LIMIT : cap_in;
	assign neg_cap = -cap;

	always_comb begin
		if (rem == '0) begin
			step = '0;
		end else if (cap_in == '0) begin
			step = rem;
		end else if (!rem[gii_pkg::WORD_W-1]) begin
			step = (rem < cap) ? rem : cap;
		end else begin
			step = (rem > neg_cap) ? rem : neg_cap;
		end
	end

	assign left = rem - step;
endmodule

@@ rtl/guarded_input_inject_drain_top.sv @@
// Guarded input inject/drain: frame classification, decision hold on torn reads,
// mouse budget drain. Depends on gii_pkg, gii_in_if, gii_out_if, gii_drain.
//
// Usage:
//   in_ch carries one frame snapshot per beat, out_ch one result per beat.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
//   only while no beat is in flight. Index values past the register list are
//   ignored.
//   A snapshot beat lands in the input register; from there it is classified,
//   the budget step is drained and the result register loads as soon as that
//   register is free or being taken. Throughput is one beat per cycle while
//   out_ch takes results: the combinational decision/drain path between the
//   input and result registers sets it.
//   When out_ch stalls, the result register holds and one more beat may wait
//   in the input register; in_ch.ready then drops until the result is taken.
//   Reset clears the held decision, remainders, mouse sequence and counters
//   and loads the register reset values (channel mask all ones).
module guarded_input_inject_drain_top #(
	parameter int unsigned CFG_IDX_W = gii_pkg::CFG_IDX_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [gii_pkg::WORD_W-1:0] cfg_data,
	gii_in_if.sink               in_ch,
	gii_out_if.source            out_ch
);
	localparam int unsigned W = gii_pkg::WORD_W;

	// configuration
	logic [W-1:0] exp_magic_q, exp_version_q, timeout_q, chan_mask_q;
	logic [gii_pkg::BIT_W-1:0] mouse_bit_q;

	// held decision and drain state
	gii_pkg::status_t lg_status_q;
	logic [W-1:0] lg_seq_q, lg_chan_q, lg_mseq_q, lg_smax_q;
	logic signed [W-1:0] lg_bx_q, lg_by_q;
	logic [W-1:0] mseq_seen_q, frames_q, applied_q;
	logic signed [W-1:0] remain_x_q, remain_y_q;

	// pipeline
	gii_pkg::in_beat_t  beat_s1;
	logic               valid_s1;
	gii_pkg::out_beat_t out_beat_q;
	logic               out_valid_q;
	logic               advance;

	// decision for the beat in the input register
	gii_pkg::status_t d_status;
	logic [W-1:0] d_seq, d_chan, d_mseq, d_smax, age;
	logic signed [W-1:0] d_bx, d_by;
	logic header_ok, torn, stale, inject, mouse_on, fresh;
	logic signed [W-1:0] src_x, src_y, step_x, step_y, left_x, left_y;
	logic signed [W-1:0] nxt_rx, nxt_ry;

	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_magic_q   <= '0;
			exp_version_q <= '0;
			timeout_q     <= '0;
			chan_mask_q   <= '1;
			mouse_bit_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gii_pkg::CFG_MAGIC:     exp_magic_q   <= cfg_data;
				gii_pkg::CFG_VERSION:   exp_version_q <= cfg_data;
				gii_pkg::CFG_TIMEOUT:   timeout_q     <= cfg_data;
				gii_pkg::CFG_CHAN_MASK: chan_mask_q   <= cfg_data;
				gii_pkg::CFG_MOUSE_BIT: mouse_bit_q   <= cfg_data[gii_pkg::BIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign header_ok = (beat_s1.header_magic == exp_magic_q) &&
		(beat_s1.header_version == exp_version_q);
	assign torn = beat_s1.seq_before != beat_s1.seq_after;
	assign age = beat_s1.now_ms - beat_s1.writer_tick;
	assign stale = (timeout_q != '0) && (age > timeout_q);

	always_comb begin
		d_status = lg_status_q;
		d_seq    = lg_seq_q;
		d_chan   = lg_chan_q;
		d_mseq   = lg_mseq_q;
		d_bx     = lg_bx_q;
		d_by     = lg_by_q;
		d_smax   = lg_smax_q;
		if (!header_ok) begin
			d_status = gii_pkg::ST_BAD;
			d_seq    = '0;
			d_chan   = '0;
			d_mseq   = '0;
			d_bx     = '0;
			d_by     = '0;
			d_smax   = '0;
		end else if (!torn) begin
			d_seq  = beat_s1.seq_after;
			d_chan = '0;
			d_mseq = '0;
			d_bx   = '0;
			d_by   = '0;
			d_smax = '0;
			if (!beat_s1.enabled) begin
				d_status = gii_pkg::ST_PASS;
			end else if (stale) begin
				d_status = gii_pkg::ST_STALE;
			end else begin
				d_status = gii_pkg::ST_INJECT;
				d_chan   = beat_s1.channels & chan_mask_q;
				d_mseq   = beat_s1.mouse_seq;
				d_bx     = beat_s1.budget_x;
				d_by     = beat_s1.budget_y;
				d_smax   = beat_s1.step_max;
			end
		end
	end

	assign inject   = d_status == gii_pkg::ST_INJECT;
	assign mouse_on = inject && d_chan[mouse_bit_q];
	assign fresh    = d_mseq != mseq_seen_q;
	assign src_x    = fresh ? d_bx : remain_x_q;
	assign src_y    = fresh ? d_by : remain_y_q;

	gii_drain u_drain_x (.rem(src_x), .cap_in(d_smax), .step(step_x), .left(left_x));
	gii_drain u_drain_y (.rem(src_y), .cap_in(d_smax), .step(step_y), .left(left_y));

	always_comb begin
		if (!inject) begin
			nxt_rx = '0;
			nxt_ry = '0;
		end else if (mouse_on) begin
			nxt_rx = left_x;
			nxt_ry = left_y;
		end else begin
			nxt_rx = remain_x_q;
			nxt_ry = remain_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			lg_status_q <= gii_pkg::ST_BAD;
			lg_seq_q    <= '0;
			lg_chan_q   <= '0;
			lg_mseq_q   <= '0;
			lg_bx_q     <= '0;
			lg_by_q     <= '0;
			lg_smax_q   <= '0;
			mseq_seen_q <= '0;
			remain_x_q  <= '0;
			remain_y_q  <= '0;
			frames_q    <= '0;
			applied_q   <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				lg_status_q <= d_status;
				lg_seq_q    <= d_seq;
				lg_chan_q   <= d_chan;
				lg_mseq_q   <= d_mseq;
				lg_bx_q     <= d_bx;
				lg_by_q     <= d_by;
				lg_smax_q   <= d_smax;
				remain_x_q  <= nxt_rx;
				remain_y_q  <= nxt_ry;
				frames_q    <= frames_q + 1'b1;
				if (mouse_on && fresh) begin
					mseq_seen_q <= d_mseq;
				end
				if (inject) begin
					applied_q <= applied_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			beat_s1 <= in_ch.data;
		end
		if (advance) begin
			out_beat_q.status        <= d_status;
			out_beat_q.seq_seen      <= d_seq;
			out_beat_q.channels_out  <= inject ? d_chan : '0;
			out_beat_q.mouse_dx      <= mouse_on ? step_x : '0;
			out_beat_q.mouse_dy      <= mouse_on ? step_y : '0;
			out_beat_q.frame_count   <= frames_q + 1'b1;
			out_beat_q.applied_count <= inject ? applied_q + 1'b1 : applied_q;
			out_beat_q.left_x        <= nxt_rx;
			out_beat_q.left_y        <= nxt_ry;
		end
	end

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ch.ready) |-> !in_ch.ready)
		else $error("input taken while both stages are full and stalled");

	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> frames_q == $past(frames_q) + 1'b1)
		else $error("frame counter did not step by one per result");

	a_applied_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !inject) |=> applied_q == $past(applied_q))
		else $error("applied counter moved on a non-injecting frame");

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_beat_q.status != gii_pkg::ST_INJECT) |->
		(out_beat_q.left_x == '0 && out_beat_q.left_y == '0 &&
		out_beat_q.mouse_dx == '0 && out_beat_q.channels_out == '0))
		else $error("non-injecting result carries budget or channels");
endmodule
